// ----- design/ari_pkg.sv -----
// ----------------------------------------------------------------------------
// ari_pkg
// Shared types, codes and helpers for the axial radius interpolator.
// ----------------------------------------------------------------------------
package ari_pkg;

    localparam int DEF_MAX_NODES = 64;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ZERO_RAD = 2'd1;
    localparam logic [1:0] STAT_EQ_POS   = 2'd2;
    localparam logic [1:0] STAT_LOAD_ACK = 2'd3;

    localparam logic REG_NODE_COUNT = 1'b0;

    localparam logic [6:0] NODE_COUNT_RST = 7'd2;

    typedef struct packed {
        logic               is_query;
        logic [5:0]         entry_index;
        logic signed [31:0] node_position;
        logic signed [31:0] radius_value;
        logic signed [31:0] query_position;
    } item_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > 52'sh0007FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -52'sh00080000000) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- design/ari_front.sv -----
// ----------------------------------------------------------------------------
// ari_front
// Accepts items, tags loads and queries, and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ari_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [5:0]         s_entry_index,
    input  logic signed [31:0] s_node_position,
    input  logic signed [31:0] s_radius_value,
    input  logic signed [31:0] s_query_position,
    output logic               q_valid,
    input  logic               q_pop,
    output ari_pkg::item_t     q_item
);
    ari_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           push;
    ari_pkg::item_t in_item;

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        in_item.is_query       = (s_func == ari_pkg::FUNC_QUERY);
        in_item.entry_index    = s_entry_index;
        in_item.node_position  = s_node_position;
        in_item.radius_value   = s_radius_value;
        in_item.query_position = s_query_position;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

// ----- design/ari_div.sv -----
// ----------------------------------------------------------------------------
// ari_div
// Serial Q16.16 divider: (num * 65536) / den, truncated toward zero and
// saturated, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ari_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [32:0] num,
    input  logic signed [32:0] den,
    output logic               done,
    output logic signed [31:0] quot
);
    localparam int Steps = 49;

    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic        neg_reg;
    logic [48:0] dvd_reg;
    logic [32:0] rem_reg;
    logic [32:0] dvs_reg;
    logic [33:0] trial;
    logic        fits;
    logic [32:0] num_mag;
    logic [32:0] den_mag;

    assign num_mag = num[32] ? 33'(-num) : 33'(num);
    assign den_mag = den[32] ? 33'(-den) : 33'(den);
    assign trial   = {rem_reg, dvd_reg[48]};
    assign fits    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= 6'(Steps);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= {num_mag[32:0], 16'd0};
            rem_reg <= '0;
            dvs_reg <= den_mag;
            neg_reg <= num[32] ^ den[32];
        end else if (cnt_reg != '0) begin
            rem_reg <= fits ? 33'(trial - {1'b0, dvs_reg}) : trial[32:0];
            dvd_reg <= {dvd_reg[47:0], fits};
        end
    end

    assign done = done_reg;

    always_comb begin
        if (!neg_reg) begin
            quot = (dvd_reg > 49'h0007FFFFFFF) ? 32'sh7FFFFFFF : dvd_reg[31:0];
        end else begin
            quot = (dvd_reg > 49'h00080000000) ? 32'sh80000000 : 32'(-dvd_reg);
        end
    end
endmodule

// ----- design/ari_mul.sv -----
// ----------------------------------------------------------------------------
// ari_mul
// Serial signed multiplier, 33 by 33 bits, one shift-add step per cycle.
// ----------------------------------------------------------------------------
module ari_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [32:0] op_a,
    input  logic signed [32:0] op_b,
    output logic               done,
    output logic signed [66:0] prod
);
    localparam int Steps = 33;

    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic        neg_reg;
    logic [32:0] mcand_reg;
    logic [32:0] hi_reg;
    logic [32:0] lo_reg;
    logic [33:0] sum;
    logic [32:0] a_mag;
    logic [32:0] b_mag;

    assign a_mag = op_a[32] ? 33'(-op_a) : 33'(op_a);
    assign b_mag = op_b[32] ? 33'(-op_b) : 33'(op_b);
    assign sum   = {1'b0, hi_reg} + {1'b0, (lo_reg[0] ? mcand_reg : 33'd0)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= 6'(Steps);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg <= a_mag;
            hi_reg    <= '0;
            lo_reg    <= b_mag;
            neg_reg   <= op_a[32] ^ op_b[32];
        end else if (cnt_reg != '0) begin
            hi_reg <= sum[33:1];
            lo_reg <= {sum[0], lo_reg[32:1]};
        end
    end

    assign done = done_reg;
    assign prod = neg_reg ? -$signed({1'b0, hi_reg, lo_reg})
                          : $signed({1'b0, hi_reg, lo_reg});
endmodule

// ----- design/ari_back.sv -----
// ----------------------------------------------------------------------------
// ari_back
// Sequencer that applies loads, rebuilds slopes, searches the table and
// evaluates radius, slope and the derived scale factors.
// ----------------------------------------------------------------------------
module ari_back #(
    parameter int MAX_NODES = ari_pkg::DEF_MAX_NODES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [6:0]         node_count,
    input  logic               cfg_wr,
    input  logic               q_valid,
    output logic               q_pop,
    input  ari_pkg::item_t     q_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_interp_radius,
    output logic signed [31:0] m_radius_slope,
    output logic signed [31:0] m_inverse_radius,
    output logic signed [31:0] m_dr_coefficient,
    output logic signed [31:0] m_area_jacobian,
    output logic [1:0]         m_status
);
    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RWAIT = 5'd1;
    localparam logic [4:0] S_DWAIT = 5'd2;
    localparam logic [4:0] S_MWAIT = 5'd3;
    localparam logic [4:0] S_RB_A  = 5'd4;
    localparam logic [4:0] S_RB_B  = 5'd5;
    localparam logic [4:0] S_RB_C  = 5'd6;
    localparam logic [4:0] S_RB_W  = 5'd7;
    localparam logic [4:0] S_SR_A  = 5'd8;
    localparam logic [4:0] S_SR_B  = 5'd9;
    localparam logic [4:0] S_IP_A  = 5'd10;
    localparam logic [4:0] S_IP_B  = 5'd11;
    localparam logic [4:0] S_IP_C  = 5'd12;
    localparam logic [4:0] S_IP_D  = 5'd13;
    localparam logic [4:0] S_IP_E  = 5'd14;
    localparam logic [4:0] S_IP_F  = 5'd15;
    localparam logic [4:0] S_INV   = 5'd16;
    localparam logic [4:0] S_INV_B = 5'd17;
    localparam logic [4:0] S_INV_C = 5'd18;
    localparam logic [4:0] S_INV_D = 5'd19;
    localparam logic [4:0] S_FIN   = 5'd20;

    logic [31:0] pos_mem [MAX_NODES];
    logic [31:0] rad_mem [MAX_NODES];
    logic [31:0] slp_mem [MAX_NODES];
    logic [31:0] pos_q;
    logic [31:0] rad_q;
    logic [31:0] slp_q;

    logic [4:0]         state_reg;
    logic [4:0]         ret_reg;
    logic [AW-1:0]      addr_reg;
    logic [AW-1:0]      i_reg;
    logic [AW-1:0]      k_reg;
    logic               stale_reg;
    logic               degen_reg;
    logic [1:0]         stat_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] xa_reg;
    logic signed [31:0] va_reg;
    logic signed [31:0] sa_reg;
    logic signed [31:0] xb_reg;
    logic signed [31:0] vb_reg;
    logic signed [31:0] sb_reg;
    logic signed [31:0] quot_reg;
    logic signed [66:0] prod_reg;
    logic signed [31:0] r_reg;
    logic signed [31:0] s_reg;
    logic signed [31:0] inv_reg;
    logic signed [31:0] drc_reg;
    logic signed [31:0] jac_reg;

    logic               div_go_reg;
    logic signed [32:0] div_num_reg;
    logic signed [32:0] div_den_reg;
    logic               div_done;
    logic signed [31:0] div_quot;
    logic               mul_go_reg;
    logic signed [32:0] mul_a_reg;
    logic signed [32:0] mul_b_reg;
    logic               mul_done;
    logic signed [66:0] mul_prod;

    logic               out_valid_reg;
    logic signed [31:0] out_r_reg;
    logic signed [31:0] out_s_reg;
    logic signed [31:0] out_inv_reg;
    logic signed [31:0] out_drc_reg;
    logic signed [31:0] out_jac_reg;
    logic [1:0]         out_stat_reg;

    logic [AW-1:0]      last_idx;
    logic               load_ok;
    logic [AW-1:0]      load_addr;
    logic               out_free;
    logic               slope_we;
    logic signed [32:0] dx;
    logic signed [32:0] ds;
    logic signed [32:0] dq;
    logic signed [51:0] interp_sum;

    always_comb begin
        int n;
        n = int'(node_count);
        if (n < 2) begin
            n = 2;
        end
        if (n > MAX_NODES) begin
            n = MAX_NODES;
        end
        last_idx = AW'(n - 1);
    end

    assign load_ok   = int'(q_item.entry_index) < MAX_NODES;
    assign load_addr = AW'(q_item.entry_index);
    assign out_free  = !out_valid_reg || m_ready;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign slope_we  = (state_reg == S_RB_W);

    assign dx = 33'(xb_reg) - 33'(xa_reg);
    assign ds = 33'(sb_reg) - 33'(sa_reg);
    assign dq = 33'(x_reg) - 33'(xb_reg);
    assign interp_sum = 52'(prod_reg >>> 16) + 52'(vb_reg);

    always_ff @(posedge aclk) begin
        if (q_pop && !q_item.is_query && load_ok) begin
            pos_mem[load_addr] <= q_item.node_position;
            rad_mem[load_addr] <= q_item.radius_value;
        end
        if (slope_we) begin
            slp_mem[i_reg] <= quot_reg;
        end
        pos_q <= pos_mem[addr_reg];
        rad_q <= rad_mem[addr_reg];
        slp_q <= slp_mem[addr_reg];
    end

    ari_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_go_reg),
        .num     (div_num_reg),
        .den     (div_den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    ari_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_go_reg),
        .op_a    (mul_a_reg),
        .op_b    (mul_b_reg),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    // Datapath registers; no reset needed.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                x_reg     <= q_item.query_position;
                i_reg     <= '0;
                degen_reg <= 1'b0;
                r_reg     <= '0;
                s_reg     <= '0;
                inv_reg   <= '0;
                drc_reg   <= '0;
                jac_reg   <= '0;
                stat_reg  <= ari_pkg::STAT_LOAD_ACK;
                addr_reg  <= AW'(0);
            end
            S_DWAIT: begin
                if (div_done) begin
                    quot_reg <= div_quot;
                end
            end
            S_MWAIT: begin
                if (mul_done) begin
                    prod_reg <= mul_prod;
                end
            end
            S_RB_A: begin
                addr_reg <= (i_reg == '0) ? AW'(0) : AW'(i_reg - 1'b1);
            end
            S_RB_B: begin
                xa_reg   <= $signed(pos_q);
                va_reg   <= $signed(rad_q);
                addr_reg <= (i_reg == last_idx) ? last_idx : AW'(i_reg + 1'b1);
            end
            S_RB_C: begin
                xb_reg      <= $signed(pos_q);
                vb_reg      <= $signed(rad_q);
                quot_reg    <= '0;
                div_num_reg <= 33'($signed(rad_q)) - 33'(va_reg);
                div_den_reg <= 33'($signed(pos_q)) - 33'(xa_reg);
            end
            S_RB_W: begin
                if (i_reg != last_idx) begin
                    i_reg <= AW'(i_reg + 1'b1);
                end else begin
                    i_reg <= '0;
                end
            end
            S_SR_A: begin
                addr_reg <= i_reg;
            end
            S_SR_B: begin
                if ($signed(pos_q) >= x_reg && $signed(pos_q) == x_reg) begin
                    r_reg <= $signed(rad_q);
                    s_reg <= $signed(slp_q);
                end else if ($signed(pos_q) >= x_reg || i_reg == last_idx) begin
                    k_reg    <= (i_reg == '0) ? AW'(1) : i_reg;
                    addr_reg <= (i_reg == '0) ? AW'(0) : AW'(i_reg - 1'b1);
                end else begin
                    i_reg <= AW'(i_reg + 1'b1);
                end
            end
            S_IP_A: begin
                xa_reg   <= $signed(pos_q);
                va_reg   <= $signed(rad_q);
                sa_reg   <= $signed(slp_q);
                addr_reg <= k_reg;
            end
            S_IP_B: begin
                xb_reg      <= $signed(pos_q);
                vb_reg      <= $signed(rad_q);
                sb_reg      <= $signed(slp_q);
                degen_reg   <= ($signed(pos_q) == xa_reg);
                quot_reg    <= '0;
                div_num_reg <= 33'($signed(rad_q)) - 33'(va_reg);
                div_den_reg <= 33'($signed(pos_q)) - 33'(xa_reg);
            end
            S_IP_C, S_IP_E: begin
                mul_a_reg <= 33'(quot_reg);
                mul_b_reg <= dq;
            end
            S_IP_D: begin
                r_reg       <= ari_pkg::sat32(interp_sum);
                vb_reg      <= sb_reg;
                va_reg      <= sa_reg;
                quot_reg    <= '0;
                div_num_reg <= ds;
                div_den_reg <= dx;
            end
            S_IP_F: begin
                s_reg <= ari_pkg::sat32(interp_sum);
            end
            S_INV: begin
                div_num_reg <= 33'sd65536;
                div_den_reg <= 33'(r_reg);
            end
            S_INV_B: begin
                inv_reg     <= quot_reg;
                div_num_reg <= -33'(s_reg);
                div_den_reg <= 33'(r_reg);
            end
            S_INV_C: begin
                drc_reg   <= quot_reg;
                mul_a_reg <= 33'(inv_reg);
                mul_b_reg <= 33'(inv_reg);
            end
            S_INV_D: begin
                jac_reg <= ari_pkg::sat32(52'(prod_reg >>> 16));
            end
            default: begin
            end
        endcase
        if (state_reg == S_INV || state_reg == S_INV_D) begin
            if (degen_reg) begin
                stat_reg <= ari_pkg::STAT_EQ_POS;
            end else if (r_reg == '0) begin
                stat_reg <= ari_pkg::STAT_ZERO_RAD;
            end else begin
                stat_reg <= ari_pkg::STAT_OK;
            end
        end
        if (state_reg == S_FIN && out_free) begin
            out_r_reg    <= r_reg;
            out_s_reg    <= s_reg;
            out_inv_reg  <= inv_reg;
            out_drc_reg  <= drc_reg;
            out_jac_reg  <= jac_reg;
            out_stat_reg <= stat_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            stale_reg     <= 1'b1;
            div_go_reg    <= 1'b0;
            mul_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            div_go_reg <= 1'b0;
            mul_go_reg <= 1'b0;
            if (state_reg == S_FIN && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                stale_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        if (!q_item.is_query) begin
                            stale_reg <= 1'b1;
                            state_reg <= S_FIN;
                        end else begin
                            state_reg <= stale_reg ? S_RB_A : S_SR_A;
                        end
                    end
                end
                S_RWAIT: begin
                    state_reg <= ret_reg;
                end
                S_DWAIT: begin
                    if (div_done) begin
                        state_reg <= ret_reg;
                    end
                end
                S_MWAIT: begin
                    if (mul_done) begin
                        state_reg <= ret_reg;
                    end
                end
                S_RB_A: begin
                    ret_reg   <= S_RB_B;
                    state_reg <= S_RWAIT;
                end
                S_RB_B: begin
                    ret_reg   <= S_RB_C;
                    state_reg <= S_RWAIT;
                end
                S_RB_C: begin
                    // Nodes at the same position give a zero slope.
                    if ($signed(pos_q) == xa_reg) begin
                        state_reg <= S_RB_W;
                    end else begin
                        div_go_reg <= 1'b1;
                        ret_reg    <= S_RB_W;
                        state_reg  <= S_DWAIT;
                    end
                end
                S_RB_W: begin
                    if (i_reg == last_idx) begin
                        stale_reg <= 1'b0;
                        state_reg <= S_SR_A;
                    end else begin
                        state_reg <= S_RB_A;
                    end
                end
                S_SR_A: begin
                    ret_reg   <= S_SR_B;
                    state_reg <= S_RWAIT;
                end
                S_SR_B: begin
                    if ($signed(pos_q) == x_reg) begin
                        state_reg <= S_INV;
                    end else if ($signed(pos_q) >= x_reg || i_reg == last_idx) begin
                        ret_reg   <= S_IP_A;
                        state_reg <= S_RWAIT;
                    end else begin
                        state_reg <= S_SR_A;
                    end
                end
                S_IP_A: begin
                    ret_reg   <= S_IP_B;
                    state_reg <= S_RWAIT;
                end
                S_IP_B: begin
                    if ($signed(pos_q) == xa_reg) begin
                        state_reg <= S_IP_C;
                    end else begin
                        div_go_reg <= 1'b1;
                        ret_reg    <= S_IP_C;
                        state_reg  <= S_DWAIT;
                    end
                end
                S_IP_C: begin
                    mul_go_reg <= 1'b1;
                    ret_reg    <= S_IP_D;
                    state_reg  <= S_MWAIT;
                end
                S_IP_D: begin
                    if (degen_reg) begin
                        state_reg <= S_IP_E;
                    end else begin
                        div_go_reg <= 1'b1;
                        ret_reg    <= S_IP_E;
                        state_reg  <= S_DWAIT;
                    end
                end
                S_IP_E: begin
                    mul_go_reg <= 1'b1;
                    ret_reg    <= S_IP_F;
                    state_reg  <= S_MWAIT;
                end
                S_IP_F: begin
                    state_reg <= S_INV;
                end
                S_INV: begin
                    if (r_reg == '0) begin
                        state_reg <= S_FIN;
                    end else begin
                        div_go_reg <= 1'b1;
                        ret_reg    <= S_INV_B;
                        state_reg  <= S_DWAIT;
                    end
                end
                S_INV_B: begin
                    div_go_reg <= 1'b1;
                    ret_reg    <= S_INV_C;
                    state_reg  <= S_DWAIT;
                end
                S_INV_C: begin
                    mul_go_reg <= 1'b1;
                    ret_reg    <= S_INV_D;
                    state_reg  <= S_MWAIT;
                end
                S_INV_D: begin
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_interp_radius  = out_r_reg;
    assign m_radius_slope   = out_s_reg;
    assign m_inverse_radius = out_inv_reg;
    assign m_dr_coefficient = out_drc_reg;
    assign m_area_jacobian  = out_jac_reg;
    assign m_status         = out_stat_reg;
endmodule

// ----- design/axial_radius_interpolator.sv -----
// A load is applied directly; a query searches the table node by node and then runs
// division and multiplication, and, after any load or node_count write, it first
// rebuilds the slope of every node in use.
// One item at a time: the next leaves the queue only once the last is done.
// Reset: synchronous, active low; node_count returns to 2 and the slopes are stale.
// ----------------------------------------------------------------------------
// axial_radius_interpolator
// Piecewise linear radius table with slope, inverse radius and Jacobian.
// ----------------------------------------------------------------------------
module axial_radius_interpolator #(
    parameter int MAX_NODES = ari_pkg::DEF_MAX_NODES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [5:0]         s_entry_index,
    input  logic signed [31:0] s_node_position,
    input  logic signed [31:0] s_radius_value,
    input  logic signed [31:0] s_query_position,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_interp_radius,
    output logic signed [31:0] m_radius_slope,
    output logic signed [31:0] m_inverse_radius,
    output logic signed [31:0] m_dr_coefficient,
    output logic signed [31:0] m_area_jacobian,
    output logic [1:0]         m_status
);
    logic [6:0]     node_count_reg;
    logic           cfg_wr;
    logic           q_valid;
    logic           q_pop;
    ari_pkg::item_t q_item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == ari_pkg::REG_NODE_COUNT);
    assign prdata = (paddr[2] == ari_pkg::REG_NODE_COUNT) ? {25'd0, node_count_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= ari_pkg::NODE_COUNT_RST;
        end else if (cfg_wr) begin
            node_count_reg <= pwdata[6:0];
        end
    end

    ari_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_entry_index    (s_entry_index),
        .s_node_position  (s_node_position),
        .s_radius_value   (s_radius_value),
        .s_query_position (s_query_position),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_item           (q_item)
    );

    ari_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .node_count       (node_count_reg),
        .cfg_wr           (cfg_wr),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_item           (q_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_interp_radius  (m_interp_radius),
        .m_radius_slope   (m_radius_slope),
        .m_inverse_radius (m_inverse_radius),
        .m_dr_coefficient (m_dr_coefficient),
        .m_area_jacobian  (m_area_jacobian),
        .m_status         (m_status)
    );

`ifndef SYNTHESIS
    // A load acknowledgment carries no numeric results.
    a_load_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ari_pkg::STAT_LOAD_ACK |->
            m_interp_radius == '0 && m_radius_slope == '0 && m_area_jacobian == '0)
        else $error("load transfer with nonzero fields");

    // A zero radius leaves the derived factors at zero.
    a_zero_rad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ari_pkg::STAT_ZERO_RAD |->
            m_inverse_radius == '0 && m_dr_coefficient == '0 && m_interp_radius == '0)
        else $error("zero radius transfer with nonzero factors");

    // An ok status means a usable radius.
    a_ok_rad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ari_pkg::STAT_OK |-> m_interp_radius != '0)
        else $error("ok status with zero radius");
`endif
endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Checks the axial radius interpolator against a behavioral predictor.
// A directed table comes first. Phases with random content follow, one for
// each node_count setting. Both handshake sides idle at random, but not in every fourth phase.
// ----------------------------------------------------------------------------
module tb;

    localparam int NODES      = ari_pkg::DEF_MAX_NODES;
    localparam int STALL_MAX  = 18;
    localparam int IDLE_LIMIT = 40000;

    typedef struct {
        logic signed [31:0] radius;
        logic signed [31:0] slope;
        logic signed [31:0] inv;
        logic signed [31:0] drc;
        logic signed [31:0] jac;
        logic [1:0]         status;
    } result_t;

    typedef struct {
        logic               func;
        logic [5:0]         idx;
        logic signed [31:0] pos;
        logic signed [31:0] rad;
        logic signed [31:0] qpos;
        bit                 typed;
        result_t            res;
    } row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_func = ari_pkg::FUNC_LOAD;
    logic [5:0]         s_entry_index = '0;
    logic signed [31:0] s_node_position = '0, s_radius_value = '0, s_query_position = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_interp_radius, m_radius_slope, m_inverse_radius;
    logic signed [31:0] m_dr_coefficient, m_area_jacobian;
    logic [1:0]         m_status;

    axial_radius_interpolator dut (.*);

    always #2 aclk = ~aclk;

    // Predictor state.
    longint  node_x[NODES];
    longint  node_r[NODES];
    longint  node_s[NODES];
    bit      slopes_dirty;
    int      node_limit;

    result_t pending_results[$];
    int      error_count = 0;
    int      idle_cycles = 0;
    bit      quiet = 1'b0;
    int      stall_left = 0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint q_divide(longint num, longint den);
        return clamp32((num * 65536) / den);
    endfunction

    // Segment gradient of radius (use_slopes = 0) or of slope between nodes a and b.
    function automatic longint gradient(bit use_slopes, int a, int b);
        longint dx;
        dx = node_x[b] - node_x[a];
        if (dx == 0) return 0;
        if (use_slopes) return q_divide(node_s[b] - node_s[a], dx);
        return q_divide(node_r[b] - node_r[a], dx);
    endfunction

    function automatic longint lerp(bit use_slopes, int k, longint x);
        longint m;
        longint anchor;
        m = gradient(use_slopes, k - 1, k);
        anchor = use_slopes ? node_s[k] : node_r[k];
        return clamp32(anchor + ((m * (x - node_x[k])) >>> 16));
    endfunction

    function automatic int nodes_in_use();
        if (node_limit < 2) return 2;
        if (node_limit > NODES) return NODES;
        return node_limit;
    endfunction

    function automatic result_t radius_at(longint x);
        result_t res;
        int      n, k;
        bit      found, flat;
        longint  r, s, inv, drc, jac;
        n = nodes_in_use();
        k = n - 1;
        found = 0;
        flat = 0;
        inv = 0;
        drc = 0;
        jac = 0;
        if (slopes_dirty) begin
            node_s[0] = gradient(0, 0, 1);
            for (int i = 1; i < n - 1; i++) node_s[i] = gradient(0, i - 1, i + 1);
            node_s[n - 1] = gradient(0, n - 2, n - 1);
            slopes_dirty = 0;
        end
        for (int i = 0; i < n; i++) begin
            if (!found && node_x[i] >= x) begin
                found = 1;
                k = i;
            end
        end
        if (found && node_x[k] == x) begin
            r = node_r[k];
            s = node_s[k];
        end else begin
            if (k == 0) k = 1;
            flat = (node_x[k] == node_x[k - 1]);
            r = lerp(0, k, x);
            s = lerp(1, k, x);
        end
        if (r != 0) begin
            inv = clamp32((64'sd1 <<< 32) / r);
            drc = q_divide(-s, r);
            jac = clamp32((inv * inv) >>> 16);
        end
        res.radius = r[31:0];
        res.slope = s[31:0];
        res.inv = inv[31:0];
        res.drc = drc[31:0];
        res.jac = jac[31:0];
        res.status = flat ? ari_pkg::STAT_EQ_POS
                          : (r == 0 ? ari_pkg::STAT_ZERO_RAD : ari_pkg::STAT_OK);
        return res;
    endfunction

    function automatic result_t predict(logic func, logic [5:0] idx,
                                        logic signed [31:0] pos, logic signed [31:0] rad,
                                        logic signed [31:0] qpos);
        result_t res;
        if (func == ari_pkg::FUNC_LOAD) begin
            node_x[idx] = longint'(pos);
            node_r[idx] = longint'(rad);
            slopes_dirty = 1;
            res = '{0, 0, 0, 0, 0, ari_pkg::STAT_LOAD_ACK};
        end else begin
            res = radius_at(longint'(qpos));
        end
        return res;
    endfunction

    // Called at a rising edge; leaves the item accepted at a later edge.
    task automatic send(logic func, logic [5:0] idx, logic signed [31:0] pos,
                        logic signed [31:0] rad, logic signed [31:0] qpos,
                        bit typed, result_t typed_res);
        int      gap;
        result_t res;
        gap = quiet ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_entry_index <= idx;
        s_node_position <= pos;
        s_radius_value <= rad;
        s_query_position <= qpos;
        do @(posedge aclk); while (!s_ready);
        res = predict(func, idx, pos, rad, qpos);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic send_load(int idx, longint pos, longint rad);
        send(ari_pkg::FUNC_LOAD, idx[5:0], pos[31:0], rad[31:0], $urandom, 0,
             '{default: '0});
    endtask

    task automatic send_query(longint x);
        send(ari_pkg::FUNC_QUERY, 6'($urandom), $urandom, $urandom, x[31:0], 0,
             '{default: '0});
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == {ari_pkg::REG_NODE_COUNT, 2'b00}) begin
            node_limit = int'(value[6:0]);
            slopes_dirty = 1;
        end
        @(posedge aclk);
    endtask

    task automatic check(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", field, want, got);
            error_count++;
        end
    endtask

    // Result side: checks each transfer and draws the next stall.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                error_count++;
            end else begin
                result_t want;
                want = pending_results.pop_front();
                check("radius", want.radius, m_interp_radius);
                check("radius_slope", want.slope, m_radius_slope);
                check("inverse_radius", want.inv, m_inverse_radius);
                check("dr_coefficient", want.drc, m_dr_coefficient);
                check("jacobian", want.jac, m_area_jacobian);
                check("status", 32'(want.status), 32'(m_status));
            end
            stall_left = quiet ? 0 : $urandom_range(0, STALL_MAX);
            m_ready <= (stall_left == 0);
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= (stall_left == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    row_t directed[$];
    int   settings[] = '{1, 3, 8, 127, 0, 5, 4, 64, 6, 2, 12, 3};

    initial begin
        node_limit = int'(ari_pkg::NODE_COUNT_RST);
        slopes_dirty = 1;
        // Table starts valid only for entries written below.
        directed = '{
            '{ari_pkg::FUNC_LOAD, 0, 32'sh0, 32'sh10000, 32'sh0, 1,
              '{0, 0, 0, 0, 0, ari_pkg::STAT_LOAD_ACK}},
            '{ari_pkg::FUNC_LOAD, 1, 32'sh10000, 32'sh20000, 32'sh7FFFFFFF, 1,
              '{0, 0, 0, 0, 0, ari_pkg::STAT_LOAD_ACK}},
            '{ari_pkg::FUNC_QUERY, 0, 32'sh0, 32'sh0, 32'sh0, 1,
              '{32'sh10000, 32'sh10000, 32'sh10000, 32'shFFFF0000, 32'sh10000,
                ari_pkg::STAT_OK}},
            '{ari_pkg::FUNC_QUERY, 0, 32'sh0, 32'sh0, 32'sh8000, 0, '{default: '0}},
            '{ari_pkg::FUNC_QUERY, 63, 32'shFFFFFFFF, 32'shFFFFFFFF, 32'sh80000000, 0,
              '{default: '0}},
            '{ari_pkg::FUNC_QUERY, 0, 32'sh0, 32'sh0, 32'sh7FFFFFFF, 0, '{default: '0}},
            '{ari_pkg::FUNC_QUERY, 0, 32'sh0, 32'sh0, 32'sh10000, 0, '{default: '0}},
            '{ari_pkg::FUNC_LOAD, 63, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0, 1,
              '{0, 0, 0, 0, 0, ari_pkg::STAT_LOAD_ACK}},
            '{ari_pkg::FUNC_LOAD, 1, 32'sh0, 32'sh0, 32'sh0, 1,
              '{0, 0, 0, 0, 0, ari_pkg::STAT_LOAD_ACK}},
            '{ari_pkg::FUNC_QUERY, 0, 32'sh0, 32'sh0, 32'sh0, 1,
              '{32'sh10000, 32'sh0, 32'sh10000, 32'sh0, 32'sh10000, ari_pkg::STAT_OK}},
            '{ari_pkg::FUNC_QUERY, 0, 32'sh0, 32'sh0, 32'sh10000, 0, '{default: '0}},
            '{ari_pkg::FUNC_QUERY, 0, 32'sh0, 32'sh0, 32'shFFFF0000, 0, '{default: '0}},
            '{ari_pkg::FUNC_LOAD, 0, 32'sh0, 32'sh0, 32'sh0, 1,
              '{0, 0, 0, 0, 0, ari_pkg::STAT_LOAD_ACK}},
            '{ari_pkg::FUNC_LOAD, 1, 32'sh10000, 32'sh0, 32'sh0, 1,
              '{0, 0, 0, 0, 0, ari_pkg::STAT_LOAD_ACK}},
            '{ari_pkg::FUNC_QUERY, 0, 32'sh0, 32'sh0, 32'sh0, 1,
              '{0, 0, 0, 0, 0, ari_pkg::STAT_ZERO_RAD}},
            '{ari_pkg::FUNC_QUERY, 0, 32'sh0, 32'sh0, 32'sh4000, 0, '{default: '0}},
            '{ari_pkg::FUNC_LOAD, 0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh0, 1,
              '{0, 0, 0, 0, 0, ari_pkg::STAT_LOAD_ACK}},
            '{ari_pkg::FUNC_LOAD, 1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0, 1,
              '{0, 0, 0, 0, 0, ari_pkg::STAT_LOAD_ACK}},
            '{ari_pkg::FUNC_QUERY, 0, 32'sh0, 32'sh0, 32'sh80000000, 0, '{default: '0}},
            '{ari_pkg::FUNC_QUERY, 0, 32'sh0, 32'sh0, 32'sh0, 0, '{default: '0}},
            '{ari_pkg::FUNC_QUERY, 0, 32'sh0, 32'sh0, 32'sh7FFFFFFF, 0, '{default: '0}},
            '{ari_pkg::FUNC_LOAD, 0, 32'sh0, 32'sh1, 32'sh0, 1,
              '{0, 0, 0, 0, 0, ari_pkg::STAT_LOAD_ACK}},
            '{ari_pkg::FUNC_QUERY, 0, 32'sh0, 32'sh0, 32'sh0, 0, '{default: '0}}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i]) begin
            send(directed[i].func, directed[i].idx, directed[i].pos, directed[i].rad,
                 directed[i].qpos, directed[i].typed, directed[i].res);
        end
        // An address past the only register must leave the table alone.
        write_reg(3'd4, 32'd9);
        send_query(32'sh0);

        foreach (settings[p]) begin
            int     n, items;
            longint x, step;
            quiet = (p % 4 == 3);
            write_reg({ari_pkg::REG_NODE_COUNT, 2'b00}, settings[p]);
            n = nodes_in_use();
            items = (n > 16) ? 12 : 30;
            // Well-formed table: ascending positions, an occasional repeated node.
            x = $signed($urandom_range(0, 32'h00FFFFFF)) - 64'sh800000;
            for (int i = 0; i < n; i++) begin
                send_load(i, x, ($urandom_range(0, 9) == 0) ? 0
                          : $signed($urandom_range(0, 32'h1FFFFF)) - 64'sh100000);
                step = ($urandom_range(0, 12) == 0) ? 0 : $urandom_range(1, 32'h40000);
                x += step;
            end
            for (int j = 0; j < items; j++) begin
                int pick;
                pick = $urandom_range(0, 9);
                if (pick < 2) begin
                    send_load($urandom_range(0, NODES - 1),
                              $signed($urandom), $signed($urandom));
                end else if (pick < 4) begin
                    send_query(node_x[$urandom_range(0, n - 1)]);
                end else if (pick < 5) begin
                    send_query($signed($urandom));
                end else begin
                    int k;
                    k = $urandom_range(0, n - 1);
                    send_query(node_x[k] + $signed($urandom_range(0, 32'h7FFFF)) - 64'sh40000);
                end
            end
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/ari_pkg.sv
design/ari_front.sv
design/ari_div.sv
design/ari_mul.sv
design/ari_back.sv
design/axial_radius_interpolator.sv
tb/sv/tb.sv
